>>> design/rswo_pkg.sv
// Shared types and constants for the raster stripe wobble offsets unit.
`timescale 1ns / 1ps
`default_nettype none
package rswo_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_LOGICAL_HEIGHT    = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_STRIPE_HEIGHT     = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_AMP_X             = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_AMP_Y             = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_SPEED             = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_BAND_HEIGHT       = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_BAND_PHASE_STEP   = 3'd6;
  localparam logic [CfgAddrW-1:0] CFG_COUNT_FROM_BOTTOM = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_STRIPE = 2'd1,
    OP_LOAD   = 2'd2
  } op_e;

  typedef struct packed {
    logic [10:0]        logical_height;
    logic [8:0]         stripe_height;
    logic signed [11:0] amp_x;
    logic signed [11:0] amp_y;
    logic signed [15:0] speed;
    logic [10:0]        band_height;
    logic [15:0]        band_phase_step;
    logic               count_from_bottom;
  } cfg_t;

  // arg carries time_step for a tick, phase_value for a load
  typedef struct packed {
    op_e         op;
    logic [15:0] arg;
    logic [9:0]  stripe_index;
    logic [12:0] source_height;
  } cmd_t;

  typedef struct packed {
    logic signed [11:0] offset_x;
    logic [11:0]        source_row;
    logic               out_of_range;
  } res_t;

endpackage
`default_nettype wire

>>> design/rswo_front.sv
// Front end: accepts input items, drops unknown operations, forms commands.
`timescale 1ns / 1ps
`default_nettype none
module rswo_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_tvalid_i,
  output logic              s_tready_o,
  input  wire  [55:0]       s_tdata_i,
  input  wire  [1:0]        s_tuser_i,
  output logic              cmd_valid_o,
  input  wire               cmd_ready_i,
  output rswo_pkg::cmd_t    cmd_o
);

  logic           valid_q, valid_d;
  rswo_pkg::cmd_t cmd_q, cmd_d;
  rswo_pkg::op_e  op;
  logic           known;

  assign op    = rswo_pkg::op_e'(s_tuser_i);
  assign known = (op == rswo_pkg::OP_TICK) || (op == rswo_pkg::OP_STRIPE) ||
                 (op == rswo_pkg::OP_LOAD);

  assign s_tready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (s_tvalid_i && s_tready_o) begin
      valid_d            = known;
      cmd_d.op           = op;
      cmd_d.arg          = (op == rswo_pkg::OP_LOAD) ? s_tdata_i[54:39] : s_tdata_i[15:0];
      cmd_d.stripe_index = s_tdata_i[25:16];
      cmd_d.source_height = s_tdata_i[38:26];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule
`default_nettype wire

>>> design/rswo_fifo.sv
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module rswo_fifo (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  rswo_pkg::cmd_t    in_cmd_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output rswo_pkg::cmd_t    out_cmd_o
);

  rswo_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_cmd_i;
  end

endmodule
`default_nettype wire

>>> design/rswo_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rswo_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [21:0] rem_i,
  input  wire  [15:0] bits_i,
  input  wire  [4:0]  steps_i,
  input  wire  [21:0] den_i,
  output logic        busy_o,
  output logic [15:0] quot_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [21:0] r_q, den_q;
  logic [15:0] b_q, q_q;
  logic [22:0] trial;
  logic        ge;

  assign trial  = {r_q, b_q[15]};
  assign ge     = trial >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= rem_i;
      b_q   <= bits_i;
      q_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? 22'(trial - {1'b0, den_q}) : trial[21:0];
      b_q <= {b_q[14:0], 1'b0};
      q_q <= {q_q[14:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> design/rswo_back.sv
// Back end: phase state, stripe sequencer, sine and power tables, result register.
`timescale 1ns / 1ps
`default_nettype none
module rswo_back #(
  parameter int MAX_LINES          = 1024,
  parameter int SINE_TABLE_DEPTH   = 1024,
  parameter int WEIGHT_TABLE_DEPTH = 1024
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  rswo_pkg::cfg_t    cfg_i,
  input  wire               cmd_valid_i,
  output logic              cmd_ready_o,
  input  rswo_pkg::cmd_t    cmd_i,
  output logic              m_tvalid_o,
  input  wire               m_tready_i,
  output rswo_pkg::res_t    res_o,
  output logic              busy_o
);

  localparam int SA = $clog2(SINE_TABLE_DEPTH);
  localparam int PA = $clog2(WEIGHT_TABLE_DEPTH + 1);
  localparam logic [12:0] MaxLinesC = 13'(MAX_LINES);
  localparam logic [12:0] SineDepthC = 13'(SINE_TABLE_DEPTH);
  localparam logic [13:0] WeightDepthC = 14'(WEIGHT_TABLE_DEPTH);
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Ln2Q30 = 64'd744261118;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [16:0] pow_rom_t [WEIGHT_TABLE_DEPTH + 1];

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    longint unsigned q, r, x, term, mag;
    longint s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q = 64'(4 * k) / SINE_TABLE_DEPTH;
      r = 64'(4 * k) - q * SINE_TABLE_DEPTH;
      if (q[0]) r = SINE_TABLE_DEPTH - r;
      x = r * HalfPiQ30 / SINE_TABLE_DEPTH;
      s = longint'(x);
      term = x;
      for (int n = 1; n <= 8; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      mag = (64'(s) * 64'd16384 + 64'd536870912) >> 30;
      if (mag > 64'd16384) mag = 64'd16384;
      rom[k] = (q >= 64'd2) ? -$signed(16'(mag)) : $signed(16'(mag));
    end
    return rom;
  endfunction

  function automatic longint unsigned log2_q30(longint unsigned v);
    int n;
    longint unsigned m, res;
    n = 0;
    for (int i = 1; i <= 12; i++) begin
      if ((v >> i) != 64'd0) n = i;
    end
    m = v << (30 - n);
    res = 64'(n) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'd2147483648) begin
        m = m >> 1;
        res = res | (64'd1 << i);
      end
    end
    return res;
  endfunction

  function automatic pow_rom_t build_pow();
    pow_rom_t rom;
    longint unsigned y, e, z, term, sh;
    longint s;
    for (int j = 0; j <= WEIGHT_TABLE_DEPTH; j++) begin
      if (j == 0) begin
        rom[j] = 17'd0;
      end else if (j >= WEIGHT_TABLE_DEPTH) begin
        rom[j] = 17'd65536;
      end else begin
        y = log2_q30(64'(WEIGHT_TABLE_DEPTH)) - log2_q30(64'(j));
        y = y * 64'd143 / 64'd100;
        e = y >> 30;
        if (e >= 64'd17) begin
          rom[j] = 17'd0;
        end else begin
          z = ((y & 64'h3FFF_FFFF) * Ln2Q30) >> 30;
          s = 64'sd1073741824;
          term = 64'd1073741824;
          for (int n = 1; n <= 14; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            if (n % 2 == 1) s = s - longint'(term);
            else s = s + longint'(term);
          end
          if (s < 0) s = 0;
          sh = 64'd14 + e;
          rom[j] = 17'((64'(s) + (64'd1 << (sh - 64'd1))) >> sh);
        end
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine();
  localparam pow_rom_t PowRom = build_pow();

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_Y0    = 4'd1;
  localparam logic [3:0] ST_CHK   = 4'd2;
  localparam logic [3:0] ST_BAND  = 4'd3;
  localparam logic [3:0] ST_BOT   = 4'd4;
  localparam logic [3:0] ST_WST   = 4'd5;
  localparam logic [3:0] ST_WDIV  = 4'd6;
  localparam logic [3:0] ST_PHASE = 4'd7;
  localparam logic [3:0] ST_RD1   = 4'd8;
  localparam logic [3:0] ST_RD2   = 4'd9;
  localparam logic [3:0] ST_M1    = 4'd10;
  localparam logic [3:0] ST_M2    = 4'd11;
  localparam logic [3:0] ST_M3    = 4'd12;
  localparam logic [3:0] ST_M4    = 4'd13;
  localparam logic [3:0] ST_RND   = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  logic [3:0]  state_q;
  logic [15:0] phase_q;
  logic        out_valid_q;
  rswo_pkg::res_t out_q, res_q;

  logic [9:0]  idx_q;
  logic [12:0] srch_q;
  logic [18:0] y0_q;
  logic [21:0] nprod_q, lsq_q;
  logic [10:0] band_q;
  logic [16:0] w_q, wp_q;
  logic [15:0] t_q;
  logic signed [15:0] s1_q, s2_q;
  logic signed [27:0] pa_q, pb_q;
  logic signed [45:0] px_q, py_q;
  logic signed [15:0] sine_rd_q;
  logic [16:0] pow_rd_q;

  logic [10:0] y0s, bh;
  logic [21:0] nfull;
  logic signed [32:0] tick_prod;

  logic        div_start, div_busy;
  logic [21:0] div_rem, div_den;
  logic [15:0] div_bits, div_quot;
  logic [4:0]  div_steps;

  logic [15:0] angle, t2;
  logic [28:0] sprod;
  logic [12:0] sx;
  logic [SA-1:0] sine_addr;
  logic [29:0] wprod;
  logic [13:0] wx;
  logic [PA-1:0] pow_addr;

  logic        xneg, yneg;
  logic [45:0] xmag, ymag;
  logic [15:0] xr;
  logic [11:0] yr, ox;
  logic signed [14:0] rowv;
  logic [12:0] hi, minsh;
  logic [11:0] row;

  assign y0s   = y0_q[10:0];
  assign bh    = (cfg_i.band_height != 11'd0) ? cfg_i.band_height : cfg_i.logical_height;
  assign nfull = {nprod_q[19:0], 2'b00};
  assign tick_prod = cfg_i.speed * $signed({1'b0, cmd_i.arg});

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign m_tvalid_o  = out_valid_q;
  assign res_o       = out_q;

  rswo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .bits_i  (div_bits),
    .steps_i (div_steps),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_bits  = {y0s, 5'b0};
    div_steps = 5'd11;
    div_den   = {11'b0, bh};
    case (state_q)
      ST_CHK: begin
        div_start = !((13'({3'b0, idx_q}) >= MaxLinesC) ||
                      (y0_q >= {8'b0, cfg_i.logical_height}));
      end
      ST_BAND: begin
        div_start = !div_busy && cfg_i.count_from_bottom;
        div_bits  = {11'(cfg_i.logical_height - 11'd1), 5'b0};
      end
      ST_WST: begin
        div_start = (nfull != lsq_q);
        div_rem   = nfull;
        div_bits  = '0;
        div_steps = 5'd16;
        div_den   = lsq_q;
      end
      default: begin
      end
    endcase
  end

  // table addressing
  assign t2        = {t_q[14:0], 1'b0} + 16'h8000;
  assign angle     = (state_q == ST_RD1) ? t_q : t2;
  assign sprod     = 29'(angle) * 29'(SINE_TABLE_DEPTH) + 29'd32768;
  assign sx        = sprod[28:16];
  assign sine_addr = (sx >= SineDepthC) ? '0 : sx[SA-1:0];
  assign wprod     = 30'(w_q) * 30'(WEIGHT_TABLE_DEPTH) + 30'd32768;
  assign wx        = wprod[29:16];
  assign pow_addr  = (wx > WeightDepthC) ? PA'(WEIGHT_TABLE_DEPTH) : wx[PA-1:0];

  always_ff @(posedge clk_i) begin
    sine_rd_q <= SineRom[sine_addr];
    pow_rd_q  <= PowRom[pow_addr];
  end

  // rounding and clamping
  always_comb begin
    xneg  = px_q[45];
    xmag  = xneg ? 46'(-px_q) : 46'(px_q);
    xr    = 16'((xmag + 46'd536870912) >> 30);
    if (xneg) begin
      ox = (xr > 16'd2048) ? 12'h800 : 12'(-xr);
    end else begin
      ox = (xr > 16'd2047) ? 12'h7FF : xr[11:0];
    end
    yneg  = py_q[45];
    ymag  = yneg ? 46'(-py_q) : 46'(py_q);
    yr    = 12'((ymag + 46'd8589934592) >> 34);
    rowv  = $signed({4'b0, y0s}) + (yneg ? -$signed({3'b0, yr}) : $signed({3'b0, yr}));
    minsh = ({4'b0, cfg_i.stripe_height} < srch_q) ? {4'b0, cfg_i.stripe_height} : srch_q;
    hi    = srch_q - minsh;
    if (rowv < 15'sd0) begin
      row = 12'd0;
    end else if (rowv > $signed({2'b0, hi})) begin
      row = (hi > 13'd4095) ? 12'd4095 : hi[11:0];
    end else begin
      row = (rowv > 15'sd4095) ? 12'd4095 : rowv[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_tready_i && (state_q != ST_FIN)) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              rswo_pkg::OP_TICK:   phase_q <= phase_q + tick_prod[27:12];
              rswo_pkg::OP_LOAD:   phase_q <= cmd_i.arg;
              rswo_pkg::OP_STRIPE: state_q <= ST_Y0;
              default: begin
              end
            endcase
          end
        end
        ST_Y0:  state_q <= ST_CHK;
        ST_CHK: state_q <= div_start ? ST_BAND : ST_FIN;
        ST_BAND: begin
          if (!div_busy) state_q <= cfg_i.count_from_bottom ? ST_BOT : ST_WST;
        end
        ST_BOT: begin
          if (!div_busy) state_q <= ST_WST;
        end
        ST_WST:  state_q <= div_start ? ST_WDIV : ST_PHASE;
        ST_WDIV: begin
          if (!div_busy) state_q <= ST_PHASE;
        end
        ST_PHASE: state_q <= ST_RD1;
        ST_RD1:   state_q <= ST_RD2;
        ST_RD2:   state_q <= ST_M1;
        ST_M1:    state_q <= ST_M2;
        ST_M2:    state_q <= ST_M3;
        ST_M3:    state_q <= ST_M4;
        ST_M4:    state_q <= ST_RND;
        ST_RND:   state_q <= ST_FIN;
        ST_FIN: begin
          if (!out_valid_q || m_tready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        idx_q  <= cmd_i.stripe_index;
        srch_q <= cmd_i.source_height;
      end
      ST_Y0: y0_q <= 19'(idx_q * cfg_i.stripe_height);
      ST_CHK: begin
        nprod_q <= 22'(y0s * 11'(cfg_i.logical_height - y0s));
        lsq_q   <= 22'(cfg_i.logical_height * cfg_i.logical_height);
        res_q   <= '{offset_x: 12'sd0, source_row: 12'd0, out_of_range: 1'b1};
      end
      ST_BAND: begin
        if (!div_busy) band_q <= div_quot[10:0];
      end
      ST_BOT: begin
        if (!div_busy) band_q <= div_quot[10:0] - band_q;
      end
      ST_WST: w_q <= 17'd65536;
      ST_WDIV: begin
        if (!div_busy) w_q <= {1'b0, div_quot};
      end
      ST_PHASE: t_q <= phase_q + 16'(cfg_i.band_phase_step * band_q);
      ST_RD2: begin
        s1_q <= sine_rd_q;
        wp_q <= pow_rd_q;
      end
      ST_M1: begin
        s2_q <= sine_rd_q;
        pa_q <= cfg_i.amp_x * s1_q;
      end
      ST_M2: px_q <= pa_q * $signed({1'b0, w_q});
      ST_M3: pb_q <= cfg_i.amp_y * s2_q;
      ST_M4: py_q <= pb_q * $signed({1'b0, wp_q});
      ST_RND: res_q <= '{offset_x: $signed(ox), source_row: row, out_of_range: 1'b0};
      ST_FIN: begin
        if (!out_valid_q || m_tready_i) out_q <= res_q;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/raster_stripe_wobble_offsets_unit.sv
// Top level of the raster stripe wobble offsets unit.
// Input channel s_axis_*: one item per handshake; tuser is the operation
// (tick, stripe, load), tdata carries time_step, stripe_index, source_height
// and phase_value. Ticks and loads update the phase and give no result;
// an unknown operation code is dropped. A stripe item gives one result item
// on m_axis_*: offset_x and source_row in tdata, out_of_range in tuser.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_data_i while idle.
// A tick or load updates the phase register after passing the front register
// and the queue. An out-of-range stripe skips the shared restoring divider;
// any other stripe waits on it (11 steps for the band, 11 more when counting
// bands from the bottom, 16 for the weight unless the stripe starts at the
// screen center). The sequencer takes no new item until its stripe result
// is in the result register.
// The front register and a two-entry queue let up to three items be taken
// while the sequencer works.
// Reset clears the phase to zero, loads the register defaults and empties
// all stages. While the receiver stalls, the result register holds and
// the sequencer waits with the next result, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module raster_stripe_wobble_offsets_unit #(
  parameter int MAX_LINES          = 1024,
  parameter int SINE_TABLE_DEPTH   = 1024,
  parameter int WEIGHT_TABLE_DEPTH = 1024
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // time_step[15:0], stripe_index[25:16], source_height[38:26], phase_value[54:39]
  input  wire  [55:0]                    s_axis_tdata,
  // operation[1:0]
  input  wire  [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // offset_x[11:0], source_row[23:12]
  output logic [23:0]                    m_axis_tdata,
  // out_of_range[0]
  output logic [0:0]                     m_axis_tuser,
  input  wire                            cfg_we_i,
  input  wire  [rswo_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire  [rswo_pkg::CfgDataW-1:0]  cfg_data_i
);

  rswo_pkg::cfg_t cfg_q;
  rswo_pkg::cmd_t front_cmd, back_cmd;
  rswo_pkg::res_t res;
  logic           front_valid, front_ready, back_valid, back_ready, back_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{logical_height: 11'd240, stripe_height: 9'd1, amp_x: 12'sd0,
                 amp_y: 12'sd0, speed: 16'sd0, band_height: 11'd0,
                 band_phase_step: 16'd0, count_from_bottom: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rswo_pkg::CFG_LOGICAL_HEIGHT: cfg_q.logical_height <= cfg_data_i[10:0];
        rswo_pkg::CFG_STRIPE_HEIGHT: begin
          cfg_q.stripe_height <= (cfg_data_i[8:0] == 9'd0) ? 9'd1 : cfg_data_i[8:0];
        end
        rswo_pkg::CFG_AMP_X:           cfg_q.amp_x <= $signed(cfg_data_i[11:0]);
        rswo_pkg::CFG_AMP_Y:           cfg_q.amp_y <= $signed(cfg_data_i[11:0]);
        rswo_pkg::CFG_SPEED:           cfg_q.speed <= $signed(cfg_data_i);
        rswo_pkg::CFG_BAND_HEIGHT:     cfg_q.band_height <= cfg_data_i[10:0];
        rswo_pkg::CFG_BAND_PHASE_STEP: cfg_q.band_phase_step <= cfg_data_i;
        rswo_pkg::CFG_COUNT_FROM_BOTTOM: cfg_q.count_from_bottom <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  rswo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  rswo_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_cmd_i    (front_cmd),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_cmd_o   (back_cmd)
  );

  rswo_back #(
    .MAX_LINES          (MAX_LINES),
    .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH),
    .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .res_o       (res),
    .busy_o      (back_busy)
  );

  assign m_axis_tdata = {res.source_row, res.offset_x};
  assign m_axis_tuser = res.out_of_range;

`ifndef SYNTH
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
    else $error("out of range result with nonzero data");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(back_busy))
    else $error("result appeared without the sequencer working");
`endif

endmodule
`default_nettype wire

>>> verif/rswo_checker.sv
// Stripe wobble predictor and result checker for the raster stripe wobble offsets unit.
`timescale 1ns / 1ps
module rswo_checker (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  input  wire                           s_axis_tready,
  input  wire  [55:0]                   s_axis_tdata,
  input  wire  [1:0]                    s_axis_tuser,
  input  wire                           m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire  [23:0]                   m_axis_tdata,
  input  wire  [0:0]                    m_axis_tuser,
  input  wire                           cfg_we_i,
  input  wire  [rswo_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire  [rswo_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int SineDepth = 1024;
  localparam int PowDepth  = 1024;
  localparam longint QOne     = 64'd1073741824;
  localparam longint HalfPiQ  = 64'd1686629713;
  localparam longint Ln2Q     = 64'd744261118;

  longint sine_tab [SineDepth];
  longint pow_tab  [PowDepth+1];

  rswo_pkg::cfg_t cfg;
  logic [15:0]    wobble_phase;
  rswo_pkg::res_t stripe_q [$];

  function automatic longint sine_value(longint k);
    longint q, r, x, s, term, mag;
    q = (4 * k) / SineDepth;
    r = 4 * k - q * SineDepth;
    if (q[0]) r = SineDepth - r;
    x = r * HalfPiQ / SineDepth;
    s = x;
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - term;
      else s = s + term;
    end
    if (s < 0) s = 0;
    mag = (s * 16384 + (64'd1 << 29)) >> 30;
    if (mag > 16384) mag = 16384;
    return (q >= 2) ? -mag : mag;
  endfunction

  function automatic longint log2_fix(longint v);
    int     n;
    longint m, res;
    n = 0;
    while ((v >> (n + 1)) != 0) n++;
    m = v << (30 - n);
    res = longint'(n) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 2 * QOne) begin
        m = m >> 1;
        res = res | (64'd1 << i);
      end
    end
    return res;
  endfunction

  function automatic longint pow_value(longint j);
    longint y, e, z, s, term;
    if (j == 0) return 0;
    if (j >= PowDepth) return 65536;
    y = log2_fix(PowDepth) - log2_fix(j);
    y = y * 143 / 100;
    e = y >> 30;
    if (e >= 17) return 0;
    z = ((y & (QOne - 1)) * Ln2Q) >> 30;
    s = QOne;
    term = QOne;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * z) >> 30) / n;
      if (n % 2 == 1) s = s - term;
      else s = s + term;
    end
    if (s < 0) s = 0;
    return (s + (64'd1 << (13 + e))) >> (14 + e);
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint half;
    half = 64'd1 << (sh - 1);
    if (v >= 0) return (v + half) >> sh;
    return -((-v + half) >> sh);
  endfunction

  function automatic longint sine_at(longint a);
    return sine_tab[(((a & 65535) * SineDepth + 32768) >> 16) % SineDepth];
  endfunction

  function automatic rswo_pkg::res_t stripe_result(longint idx, longint src_h);
    longint L, S, cnt, y0, w, widx, wp, bh, bands, band, t, t2, ox, shift, row, hi;
    rswo_pkg::res_t r;
    L = cfg.logical_height;
    S = cfg.stripe_height;
    r = '0;
    cnt = (L + S - 1) / S;
    if (cnt > 1024) cnt = 1024;
    if (idx >= cnt) begin
      r.out_of_range = 1'b1;
      return r;
    end
    y0 = idx * S;
    w = ((4 * y0 * (L - y0)) << 16) / (L * L);
    widx = (w * PowDepth + 32768) >> 16;
    if (widx > PowDepth) widx = PowDepth;
    wp = pow_tab[widx];
    bh = (cfg.band_height != 0) ? longint'(cfg.band_height) : L;
    bands = (L + bh - 1) / bh;
    band = y0 / bh;
    if (cfg.count_from_bottom) band = bands - 1 - band;
    t = (longint'(wobble_phase) + longint'(cfg.band_phase_step) * band) & 65535;
    ox = round_away(longint'(cfg.amp_x) * sine_at(t) * w, 30);
    if (ox > 2047) ox = 2047;
    if (ox < -2048) ox = -2048;
    t2 = (2 * t + 32768) & 65535;
    shift = round_away(longint'(cfg.amp_y) * sine_at(t2) * wp, 34);
    row = y0 + shift;
    hi = src_h - ((S < src_h) ? S : src_h);
    if (row > hi) row = hi;
    if (row < 0) row = 0;
    if (row > 4095) row = 4095;
    r.offset_x = ox[11:0];
    r.source_row = row[11:0];
    return r;
  endfunction

  initial begin
    for (int k = 0; k < SineDepth; k++) sine_tab[k] = sine_value(k);
    for (int j = 0; j <= PowDepth; j++) pow_tab[j] = pow_value(j);
  end

  assign pending_o = stripe_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint         prod;
    int             errs;
    rswo_pkg::res_t exp_r, got;
    if (!rst_ni) begin
      cfg.logical_height <= 11'd240;
      cfg.stripe_height <= 9'd1;
      cfg.amp_x <= '0;
      cfg.amp_y <= '0;
      cfg.speed <= '0;
      cfg.band_height <= '0;
      cfg.band_phase_step <= '0;
      cfg.count_from_bottom <= 1'b0;
      wobble_phase <= '0;
      fail_count_o <= 0;
      stripe_q.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          rswo_pkg::CFG_LOGICAL_HEIGHT:    cfg.logical_height <= cfg_data_i[10:0];
          rswo_pkg::CFG_STRIPE_HEIGHT:     cfg.stripe_height <=
                                     (cfg_data_i[8:0] == 0) ? 9'd1 : cfg_data_i[8:0];
          rswo_pkg::CFG_AMP_X:             cfg.amp_x <= cfg_data_i[11:0];
          rswo_pkg::CFG_AMP_Y:             cfg.amp_y <= cfg_data_i[11:0];
          rswo_pkg::CFG_SPEED:             cfg.speed <= cfg_data_i;
          rswo_pkg::CFG_BAND_HEIGHT:       cfg.band_height <= cfg_data_i[10:0];
          rswo_pkg::CFG_BAND_PHASE_STEP:   cfg.band_phase_step <= cfg_data_i;
          rswo_pkg::CFG_COUNT_FROM_BOTTOM: cfg.count_from_bottom <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (rswo_pkg::op_e'(s_axis_tuser))
          rswo_pkg::OP_TICK: begin
            prod = longint'(cfg.speed) * longint'(s_axis_tdata[15:0]);
            wobble_phase <= wobble_phase + 16'(prod >>> 12);
          end
          rswo_pkg::OP_LOAD: wobble_phase <= s_axis_tdata[54:39];
          rswo_pkg::OP_STRIPE: stripe_q.push_back(stripe_result(s_axis_tdata[25:16],
                                                                s_axis_tdata[38:26]));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset_x = m_axis_tdata[11:0];
        got.source_row = m_axis_tdata[23:12];
        got.out_of_range = m_axis_tuser[0];
        if (stripe_q.size() == 0) begin
          $display("%0t: unexpected result item %h/%h", $time, m_axis_tdata, m_axis_tuser);
          errs++;
        end else begin
          exp_r = stripe_q.pop_front();
          if (got.offset_x !== exp_r.offset_x) begin
            $display("%0t: offset_x expected %0d got %0d", $time, exp_r.offset_x, got.offset_x);
            errs++;
          end
          if (got.source_row !== exp_r.source_row) begin
            $display("%0t: source_row expected %0d got %0d", $time, exp_r.source_row,
                     got.source_row);
            errs++;
          end
          if (got.out_of_range !== exp_r.out_of_range) begin
            $display("%0t: out_of_range expected %0b got %0b", $time, exp_r.out_of_range,
                     got.out_of_range);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

>>> verif/testbench.sv
// Stimulus and verdict for the raster stripe wobble offsets unit.
`timescale 1ns / 1ps
module testbench;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [55:0]                   s_axis_tdata = '0;
  logic [1:0]                    s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          cfg_we_i = 1'b0;
  logic [rswo_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [rswo_pkg::CfgDataW-1:0] cfg_data_i = '0;
  int                            fail_count, pending;
  bit                            calm = 1'b0;
  int                            cur_lh = 240, cur_sh = 1;

  always #5 clk_i = ~clk_i;

  raster_stripe_wobble_offsets_unit dut (.*);

  rswo_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(logic [rswo_pkg::CfgAddrW-1:0] addr, int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_data_i = value[15:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (addr == rswo_pkg::CFG_LOGICAL_HEIGHT) cur_lh = value & 16'h7ff;
    if (addr == rswo_pkg::CFG_STRIPE_HEIGHT) begin
      cur_sh = ((value & 16'h1ff) == 0) ? 1 : (value & 16'h1ff);
    end
  endtask

  // returns right after the accepting edge with the item still driven
  task automatic send_item(logic [1:0] op, int ts, int idx, int srch, int pv);
    bit hs;
    while (!calm && $urandom_range(0, 99) < 29) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {1'b0, pv[15:0], srch[12:0], idx[9:0], ts[15:0]};
    hs = 1'b0;
    while (!hs) begin
      #1 hs = s_axis_tready;
      @(posedge clk_i);
      if (!hs) @(negedge clk_i);
    end
  endtask

  task automatic drain_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
  endtask

  task automatic set_all(int lh, int sh, int ax, int ay, int spd, int bh, int bps, int cfb);
    write_reg(rswo_pkg::CFG_LOGICAL_HEIGHT, lh);
    write_reg(rswo_pkg::CFG_STRIPE_HEIGHT, sh);
    write_reg(rswo_pkg::CFG_AMP_X, ax);
    write_reg(rswo_pkg::CFG_AMP_Y, ay);
    write_reg(rswo_pkg::CFG_SPEED, spd);
    write_reg(rswo_pkg::CFG_BAND_HEIGHT, bh);
    write_reg(rswo_pkg::CFG_BAND_PHASE_STEP, bps);
    write_reg(rswo_pkg::CFG_COUNT_FROM_BOTTOM, cfb);
  endtask

  task automatic random_items(int n);
    int pick, cnt, idx, srch;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      cnt = (cur_lh + cur_sh - 1) / cur_sh;
      if (cnt > 1024) cnt = 1024;
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, (cnt > 0) ? cnt - 1 : 0);
      srch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      if (pick < 60)
        send_item(rswo_pkg::OP_STRIPE, $urandom, idx, srch, $urandom);
      else if (pick < 80)
        send_item(rswo_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 94)
        send_item(rswo_pkg::OP_LOAD, $urandom, $urandom, $urandom, $urandom);
      else
        send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults
    send_item(rswo_pkg::OP_STRIPE, 0, 0, 240, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 120, 4096, 0);
    drain_idle();

    set_all(240, 4, 2047, -2048, 1234, 0, 0, 0);
    send_item(rswo_pkg::OP_LOAD, 0, 0, 0, 16'h0000);
    send_item(rswo_pkg::OP_STRIPE, 0, 0, 240, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 30, 240, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 59, 240, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 60, 240, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 1023, 8191, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 20, 0, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 20, 1, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 45, 8191, 0);
    send_item(rswo_pkg::OP_TICK, 65535, 0, 0, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 15, 240, 0);
    send_item(rswo_pkg::OP_TICK, 0, 0, 0, 0);
    send_item(2'd3, 65535, 1023, 8191, 65535);
    send_item(rswo_pkg::OP_LOAD, 0, 0, 0, 16'hffff);
    send_item(rswo_pkg::OP_STRIPE, 0, 40, 4096, 0);
    send_item(rswo_pkg::OP_LOAD, 0, 0, 0, 16'h4000);
    send_item(rswo_pkg::OP_STRIPE, 0, 10, 240, 0);
    drain_idle();

    // zero logical height: every stripe out of range
    set_all(0, 1, 100, 100, 0, 0, 0, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 0, 100, 0);
    send_item(rswo_pkg::OP_STRIPE, 0, 5, 100, 0);
    drain_idle();

    set_all(1024, 1, -2048, 2047, -32768, 64, 4096, 1);
    random_items(80);
    drain_idle();

    calm = 1'b1;
    set_all(480, 3, 800, -900, 32767, 1024, 65535, 0);
    random_items(80);
    drain_idle();
    calm = 1'b0;

    set_all(1, 256, 2047, 2047, 500, 1, 12345, 1);
    random_items(30);
    drain_idle();

    set_all(1024, 256, -1000, -2048, -7, 2047 & 16'h3ff, 32768, 0);
    random_items(30);
    drain_idle();

    for (int p = 0; p < 4; p++) begin
      set_all($urandom_range(1, 1024), $urandom_range(1, 16), $urandom_range(0, 4095),
              $urandom_range(0, 4095), $urandom, $urandom_range(0, 300), $urandom,
              $urandom_range(0, 1));
      random_items(55);
      drain_idle();
    end
    write_reg(rswo_pkg::CFG_STRIPE_HEIGHT, 0);
    random_items(10);
    drain_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> raster_stripe_wobble_offsets_unit.f
design/rswo_pkg.sv
design/rswo_front.sv
design/rswo_fifo.sv
design/rswo_div.sv
design/rswo_back.sv
design/raster_stripe_wobble_offsets_unit.sv
verif/rswo_checker.sv
verif/testbench.sv
